// ===== hdl/csmt_pkg.sv =====
// Package for the constant-speed mover: opcodes, widths and shared types.
package csmt_pkg;

  localparam int CoordW = 32;
  localparam int GapW   = 33;
  localparam int MagW   = 32;
  localparam int SqW    = 66;
  localparam int DistW  = 34;
  localparam int StepW  = 48;
  localparam int QuoW   = 50;
  localparam int CntW   = 7;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_MOVE = 2'd1,
    OP_TICK = 2'd2,
    OP_STOP = 2'd3
  } opcode_t;

  // Command for the shared iterative unit
  typedef enum logic [2:0] {
    U_SQRT = 3'b001,
    U_DIV  = 3'b010,
    U_MUL  = 3'b100
  } unit_op_t;

  typedef struct packed {
    logic            start;
    unit_op_t        op;
    logic [SqW-1:0]  a;
    logic [QuoW-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic            done;
    logic [SqW-1:0]  res;
  } unit_rsp_t;

endpackage

// ===== hdl/csmt_unit.sv =====
// Shared iterative unit: one bit per cycle square root, divide and multiply.
module csmt_unit import csmt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic            busy_r, busy_nxt;
  unit_op_t        op_r, op_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [SqW-1:0]  a_r, a_nxt;     // dividend / radicand / multiplier shift
  logic [QuoW-1:0] b_r, b_nxt;     // divisor / multiplicand
  logic [SqW+1:0]  rem_r, rem_nxt; // partial remainder or product accumulator
  logic [SqW-1:0]  q_r, q_nxt;
  logic            done_r, done_nxt;
  logic [SqW+1:0]  trial;
  logic [SqW+1:0]  shifted;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    shifted  = '0;
    trial    = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      a_nxt    = req.a;
      b_nxt    = req.b;
      rem_nxt  = '0;
      q_nxt    = '0;
      case (req.op)
        U_SQRT:  cnt_nxt = CntW'(SqW / 2);
        U_DIV:   cnt_nxt = CntW'(SqW);
        U_MUL:   cnt_nxt = CntW'(QuoW);
        default: cnt_nxt = '0;
      endcase
    end else if (busy_r) begin
      case (op_r)
        // Restoring square root, two radicand bits per step
        U_SQRT: begin
          shifted = {rem_r[SqW-1:0], a_r[SqW-1 -: 2]};
          trial   = {q_r[SqW-1:0], 2'b01};
          a_nxt   = {a_r[SqW-3:0], 2'b00};
          if (shifted >= trial) begin
            rem_nxt = shifted - trial;
            q_nxt   = {q_r[SqW-2:0], 1'b1};
          end else begin
            rem_nxt = shifted;
            q_nxt   = {q_r[SqW-2:0], 1'b0};
          end
        end
        // Restoring division, one quotient bit per step
        U_DIV: begin
          shifted = {rem_r[SqW:0], a_r[SqW-1]};
          trial   = {{(SqW+2-QuoW){1'b0}}, b_r};
          a_nxt   = {a_r[SqW-2:0], 1'b0};
          if (shifted >= trial) begin
            rem_nxt = shifted - trial;
            q_nxt   = {q_r[SqW-2:0], 1'b1};
          end else begin
            rem_nxt = shifted;
            q_nxt   = {q_r[SqW-2:0], 1'b0};
          end
        end
        // Shift-add multiply, multiplier bits from the top
        U_MUL: begin
          shifted = {rem_r[SqW:0], 1'b0};
          trial   = a_r[QuoW-1] ? shifted + {{(SqW+2-QuoW){1'b0}}, b_r} : shifted;
          rem_nxt = trial;
          q_nxt   = trial[SqW-1:0];
          a_nxt   = {a_r[SqW-2:0], 1'b0};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= U_SQRT;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = q_r;

endmodule

// ===== hdl/constant_speed_move_to_target_top.sv =====
// Top level of the constant-speed mover: sequencer, state and stream ports.
//
// One request is handled at a time. Set position and stop go straight to output.
// Start move runs three squaring passes, a square root and, for a nonzero
// speed, a divide through one shared bit-serial unit. A tick while moving
// runs the same squares and root, then a step multiply and, unless it
// arrives, a scaling multiply and a divide for each axis. The single
// shared unit retires one bit per cycle. in_tready is low while a request
// is in progress; a finished result waits in the output register until taken.
module constant_speed_move_to_target_top import csmt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // tdata: opcode[1:0], coord_x[33:2], coord_y[65:34], coord_z[97:66],
  //        move_speed[129:98], elapsed_time[161:130], zero fill to 168
  input  logic [167:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], arrived[96],
  //        is_moving[97], travel_time[129:98], zero_speed[130], zero fill
  output logic [135:0]  out_tdata
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DEC   = 11'b00000000010,
    S_SQ    = 11'b00000000100,
    S_SQW   = 11'b00000001000,
    S_RT    = 11'b00000010000,
    S_RTW   = 11'b00000100000,
    S_MULW  = 11'b00001000000,
    S_CHK   = 11'b00010000000,
    S_DIVW  = 11'b00100000000,
    S_ADV   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  opcode_t op_r;
  logic signed [CoordW-1:0] px_r, py_r, pz_r, gx_r, gy_r, gz_r;
  logic [CoordW-1:0] speed_r, dt_r, ttime_r;
  logic moving_r, arrived_r, zspd_r, ovalid_r;
  logic [1:0] axis_r;
  logic [SqW-1:0] sum_r;
  logic [DistW-1:0] dist_r;
  logic [StepW-1:0] step_r;
  logic [CoordW-1:0] outx_r, outy_r, outz_r;
  unit_req_t req;
  unit_rsp_t rsp;
  logic signed [GapW-1:0] gap;
  logic [MagW-1:0] gmag;
  logic [QuoW-1:0] qsel;

  csmt_unit u_unit (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  // Gap on the selected axis
  always_comb begin
    case (axis_r)
      2'd0:    gap = GapW'(gx_r) - GapW'(px_r);
      2'd1:    gap = GapW'(gy_r) - GapW'(py_r);
      default: gap = GapW'(gz_r) - GapW'(pz_r);
    endcase
    gmag = gap[GapW-1] ? MagW'(-gap) : MagW'(gap);
    qsel = rsp.res[QuoW-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    req       = '{start: 1'b0, op: U_SQRT, a: '0, b: '0};
    case (state_r)
      S_IDLE: if (in_tvalid && !ovalid_r) state_nxt = S_DEC;
      S_DEC: begin
        if ((op_r == OP_MOVE) || (op_r == OP_TICK && moving_r)) state_nxt = S_SQ;
        else state_nxt = S_OUT;
      end
      S_SQ: begin
        req = '{start: 1'b1, op: U_MUL, a: {{(SqW-QuoW){1'b0}}, QuoW'(gmag)},
                b: QuoW'(gmag)};
        state_nxt = S_SQW;
      end
      S_SQW: if (rsp.done) state_nxt = (axis_r == 2'd2) ? S_RT : S_SQ;
      S_RT: begin
        req = '{start: 1'b1, op: U_SQRT, a: sum_r, b: '0};
        state_nxt = S_RTW;
      end
      S_RTW: if (rsp.done) begin
        if (op_r == OP_MOVE) begin
          if (speed_r != '0) begin
            req = '{start: 1'b1, op: U_DIV, a: SqW'({rsp.res[DistW-1:0], 16'h0}),
                    b: QuoW'(speed_r)};
            state_nxt = S_DIVW;
          end else state_nxt = S_OUT;
        end else begin
          req = '{start: 1'b1, op: U_MUL, a: SqW'(dt_r), b: QuoW'(speed_r)};
          state_nxt = S_MULW;
        end
      end
      S_MULW: if (rsp.done) state_nxt = S_CHK;
      S_CHK: begin
        if (StepW'(step_r) >= StepW'(dist_r)) state_nxt = S_OUT;
        else begin
          req = '{start: 1'b1, op: U_MUL, a: SqW'(gmag), b: QuoW'(step_r)};
          state_nxt = S_ADV;
        end
      end
      S_ADV: if (rsp.done) begin
        req = '{start: 1'b1, op: U_DIV, a: rsp.res, b: QuoW'(dist_r)};
        state_nxt = S_DIVW;
      end
      S_DIVW: if (rsp.done) begin
        if (op_r == OP_MOVE || axis_r == 2'd2) state_nxt = S_OUT;
        else state_nxt = S_CHK;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      px_r <= '0; py_r <= '0; pz_r <= '0;
      gx_r <= '0; gy_r <= '0; gz_r <= '0;
      speed_r <= '0; moving_r <= 1'b0; ovalid_r <= 1'b0;
      op_r <= OP_SET; axis_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid && !ovalid_r) begin
          op_r      <= opcode_t'(in_tdata[1:0]);
          dt_r      <= in_tdata[161:130];
          arrived_r <= 1'b0;
          zspd_r    <= 1'b0;
          ttime_r   <= '0;
          axis_r    <= '0;
          sum_r     <= '0;
          case (opcode_t'(in_tdata[1:0]))
            OP_SET: begin
              px_r <= in_tdata[33:2]; py_r <= in_tdata[65:34]; pz_r <= in_tdata[97:66];
            end
            OP_MOVE: begin
              gx_r <= in_tdata[33:2]; gy_r <= in_tdata[65:34]; gz_r <= in_tdata[97:66];
              speed_r  <= in_tdata[129:98];
              moving_r <= 1'b1;
              if (in_tdata[129:98] == '0) begin
                zspd_r  <= 1'b1;
                ttime_r <= '1;
              end
            end
            OP_STOP: moving_r <= 1'b0;
            default: ;
          endcase
        end
        S_SQW: if (rsp.done) begin
          sum_r  <= sum_r + rsp.res;
          axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 2'd1;
        end
        S_RTW: if (rsp.done) dist_r <= rsp.res[DistW-1:0];
        S_MULW: if (rsp.done) step_r <= rsp.res[StepW+15:16];
        S_CHK: if (StepW'(step_r) >= StepW'(dist_r)) begin
          arrived_r <= 1'b1;
          moving_r  <= 1'b0;
          px_r <= gx_r; py_r <= gy_r; pz_r <= gz_r;
        end
        S_DIVW: if (rsp.done) begin
          if (op_r == OP_MOVE) begin
            ttime_r <= (rsp.res[SqW-1:32] != '0) ? '1 : rsp.res[31:0];
          end else begin
            case (axis_r)
              2'd0: px_r <= gap[GapW-1] ? px_r - qsel[31:0] : px_r + qsel[31:0];
              2'd1: py_r <= gap[GapW-1] ? py_r - qsel[31:0] : py_r + qsel[31:0];
              default: pz_r <= gap[GapW-1] ? pz_r - qsel[31:0] : pz_r + qsel[31:0];
            endcase
            axis_r <= axis_r + 2'd1;
          end
        end
        S_OUT: begin
          outx_r <= px_r; outy_r <= py_r; outz_r <= pz_r;
          ovalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'b0, zspd_r, ttime_r, moving_r, arrived_r, outz_r, outy_r, outx_r};

`ifndef SYNTHESIS
  // No new request while a result is pending
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept with result pending");
  // Arrival always ends the move
  a_arrive_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[96]) |-> !out_tdata[97]) else $error("arrived while moving");
  // Zero speed saturates travel time
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[130]) |-> (out_tdata[129:98] == 32'hFFFFFFFF))
    else $error("zero speed not saturated");
`endif

endmodule
